### sv/tcph_pkg.sv
`default_nettype none

package tcph_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_IP_FAMILY = 2'd0;
    localparam logic [1:0] CFG_SRC_HIGH  = 2'd1;
    localparam logic [1:0] CFG_SRC_LOW   = 2'd2;

    // ip protocol numbers that produce a checksum
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // target checksum field
    localparam logic KIND_TCP = 1'b0;
    localparam logic KIND_UDP = 1'b1;

    // ip family codes
    localparam logic FAMILY_IPV4 = 1'b0;
    localparam logic FAMILY_IPV6 = 1'b1;

    typedef struct packed {
        logic [15:0] data_word;
        logic        odd_byte;
        logic        last;
        logic [7:0]  protocol;
        logic [15:0] segment_length;
        logic [63:0] destination_high;
        logic [63:0] destination_low;
    } t_in_item;

    typedef struct packed {
        logic [15:0] checksum_value;
        logic        target_kind;
    } t_out_item;

    // partial sums handed from the accumulate stage to the final stage
    typedef struct packed {
        logic [15:0] data_sum;
        logic [15:0] hdr_sum;
        logic        kind;
    } t_part_sum;

    // 16-bit add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // plain sum of the four 16-bit words of a 64-bit value
    function automatic logic [17:0] sum4(input logic [63:0] v);
        return {2'b00, v[63:48]} + {2'b00, v[47:32]}
             + {2'b00, v[31:16]} + {2'b00, v[15:0]};
    endfunction

    // fold a wide sum back to 16 bits, ones' complement style
    function automatic logic [15:0] fold(input logic [20:0] s);
        logic [16:0] x;
        x = {1'b0, s[15:0]} + {12'd0, s[20:16]};
        return x[15:0] + {15'd0, x[16]};
    endfunction

endpackage

`default_nettype wire

### sv/transport_checksum_pseudo_header_core.sv
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+-------------------------------
// in      | input     | i_in_valid  / o_in_ready   | i_in_data  (tcph_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_ready  | o_out_data (tcph_pkg::t_out_item)
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one input transaction per cycle sustained while no stalled result fills every stage; a
// checksum's last word passes the input register, accumulate stage and result register
// the feedback loop is the 16-bit end-around-carry add on the running sum
// reset (synchronous, active low) clears valids, running sum and config registers
// a stalled result holds only the occupied stages behind it; the input stays ready
// while any stage is empty; config writes always taken, source sum registered from them
`default_nettype none

module transport_checksum_pseudo_header_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // segment words
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire tcph_pkg::t_in_item i_in_data,
    // checksum results
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tcph_pkg::t_out_item o_out_data,
    // configuration writes
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [1:0]           i_cfg_index,
    input  wire [63:0]          i_cfg_data
);

    // configuration registers
    logic        r_ip_family;
    logic [63:0] r_src_high;
    logic [63:0] r_src_low;
    // folded source address words, kept up to date from the registers
    logic [15:0] r_src_sum;
    logic [15:0] n_src_sum;

    // stage a: input register
    logic               r_a_valid;
    tcph_pkg::t_in_item r_a;
    // stage b: running sum and per-segment partial sums
    logic                r_b_valid;
    tcph_pkg::t_part_sum r_b;
    tcph_pkg::t_part_sum n_b;
    logic [15:0]         r_run;
    logic [15:0]         n_run;
    // stage c: result register
    logic                r_out_valid;
    tcph_pkg::t_out_item r_out;
    tcph_pkg::t_out_item n_out;

    logic        en_a;
    logic        en_b;
    logic        en_c;
    logic [15:0] word_masked;
    logic        is_tcp;
    logic        is_udp;
    logic [20:0] hdr_wide;
    logic [17:0] final_wide;

    // stage enables: a stage loads when it is empty or its content moves on
    assign en_c       = !r_out_valid || i_out_ready;
    assign en_b       = !r_b_valid || en_c;
    assign en_a       = !r_a_valid || en_b;
    assign o_in_ready = en_a;

    assign o_cfg_ready = 1'b1;

    // config register writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_family <= tcph_pkg::FAMILY_IPV4;
            r_src_high  <= '0;
            r_src_low   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tcph_pkg::CFG_IP_FAMILY: r_ip_family <= i_cfg_data[0];
                tcph_pkg::CFG_SRC_HIGH:  r_src_high  <= i_cfg_data;
                tcph_pkg::CFG_SRC_LOW:   r_src_low   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // source address contribution: eight words for ipv6, two for ipv4
    always_comb begin
        if (r_ip_family == tcph_pkg::FAMILY_IPV6) begin
            n_src_sum = tcph_pkg::fold({3'd0, tcph_pkg::sum4(r_src_high)}
                                     + {3'd0, tcph_pkg::sum4(r_src_low)});
        end else begin
            n_src_sum = tcph_pkg::fold({5'd0, r_src_low[31:16]}
                                     + {5'd0, r_src_low[15:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_sum <= '0;
        end else begin
            r_src_sum <= n_src_sum;
        end
    end

    // stage a
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_in_valid) begin
            r_a <= i_in_data;
        end
    end

    // stage b logic: odd trailing byte gets a zero low byte
    assign word_masked = r_a.odd_byte ? {r_a.data_word[15:8], 8'h00} : r_a.data_word;
    assign is_tcp      = (r_a.protocol == tcph_pkg::PROTO_TCP);
    assign is_udp      = (r_a.protocol == tcph_pkg::PROTO_UDP);

    // destination words plus protocol and length words of the pseudo-header
    always_comb begin
        if (r_ip_family == tcph_pkg::FAMILY_IPV6) begin
            hdr_wide = {3'd0, tcph_pkg::sum4(r_a.destination_high)}
                     + {3'd0, tcph_pkg::sum4(r_a.destination_low)};
        end else begin
            hdr_wide = {5'd0, r_a.destination_low[31:16]}
                     + {5'd0, r_a.destination_low[15:0]};
        end
        hdr_wide = hdr_wide + {13'd0, r_a.protocol} + {5'd0, r_a.segment_length};
    end

    always_comb begin
        n_b.data_sum = tcph_pkg::oc_add(r_run, word_masked);
        n_b.hdr_sum  = tcph_pkg::fold(hdr_wide);
        n_b.kind     = is_udp ? tcph_pkg::KIND_UDP : tcph_pkg::KIND_TCP;
        // running sum restarts after the last word of a segment
        n_run        = r_a.last ? 16'd0 : n_b.data_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_run     <= '0;
        end else if (en_b) begin
            // only a last word of tcp or udp yields a result
            r_b_valid <= r_a_valid && r_a.last && (is_tcp || is_udp);
            if (r_a_valid) begin
                r_run <= n_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && r_a_valid) begin
            r_b <= n_b;
        end
    end

    // stage c: combine data, source and header sums, then invert
    assign final_wide = {2'd0, r_b.data_sum} + {2'd0, r_b.hdr_sum} + {2'd0, r_src_sum};

    always_comb begin
        n_out.checksum_value = ~tcph_pkg::fold({3'd0, final_wide});
        n_out.target_kind    = r_b.kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_c) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && r_b_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // input back-pressure only when every stage is full and the output is blocked
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && r_a_valid && r_b_valid))
        else $error("input stalled while a stage is free");

    // running sum is cleared once a last word passes the accumulate stage
    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && en_b && r_a.last) |=> (r_run == 16'd0))
        else $error("running sum not cleared after last word");

    // a word that is not last never creates a result candidate
    a_no_result_mid_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && en_b && !r_a.last) |=> !r_b_valid)
        else $error("result raised for a word that is not last");

    // a held result keeps its checksum while the consumer stalls
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
